>>> rtl/assert_macros.svh
// assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/lboc_pkg.sv
package lboc_pkg;
  localparam int CodeW = 21;
  typedef logic [3:0] cls_t;
  typedef logic [1:0] act_t;

  localparam cls_t C_OP = 4'd0;
  localparam cls_t C_CL = 4'd1;
  localparam cls_t C_QU = 4'd2;
  localparam cls_t C_NS = 4'd3;
  localparam cls_t C_EX = 4'd4;
  localparam cls_t C_GL = 4'd5;
  localparam cls_t C_BA = 4'd6;
  localparam cls_t C_BB = 4'd7;
  localparam cls_t C_IN = 4'd8;
  localparam cls_t C_PR = 4'd9;
  localparam cls_t C_PO = 4'd10;
  localparam cls_t C_NU = 4'd11;
  localparam cls_t C_AL = 4'd12;
  localparam cls_t C_ID = 4'd13;
  localparam cls_t C_CM = 4'd14;
  localparam cls_t C_SP = 4'd15;

  localparam act_t ACT_D = 2'd0;
  localparam act_t ACT_I = 2'd1;
  localparam act_t ACT_P = 2'd2;

  localparam logic [CodeW-1:0] CodeNul = 21'h0;
  localparam logic [CodeW-1:0] CodeLf = 21'h0A;

  function automatic logic in_r(logic [CodeW-1:0] c, int lo, int hi);
    return (c >= CodeW'(lo)) && (c <= CodeW'(hi));
  endfunction

  function automatic cls_t classify(logic [CodeW-1:0] c);
    cls_t r;
    r = C_AL;
    if (in_r(c,'h0009,'h0009)) r = C_SP;
    if (in_r(c,'h0020,'h0020)) r = C_SP;
    if (in_r(c,'h0021,'h0021)) r = C_EX;
    if (in_r(c,'h0022,'h0022)) r = C_QU;
    if (in_r(c,'h0024,'h0024)) r = C_PR;
    if (in_r(c,'h0025,'h0025)) r = C_PO;
    if (in_r(c,'h0027,'h0027)) r = C_QU;
    if (in_r(c,'h0028,'h0028)) r = C_OP;
    if (in_r(c,'h0029,'h0029)) r = C_CL;
    if (in_r(c,'h002C,'h002D)) r = C_BA;
    if (in_r(c,'h002F,'h002F)) r = C_BA;
    if (in_r(c,'h0030,'h0039)) r = C_NU;
    if (in_r(c,'h003A,'h003B)) r = C_BA;
    if (in_r(c,'h003F,'h003F)) r = C_EX;
    if (in_r(c,'h005B,'h005B)) r = C_OP;
    if (in_r(c,'h005D,'h005D)) r = C_CL;
    if (in_r(c,'h007B,'h007B)) r = C_OP;
    if (in_r(c,'h007D,'h007D)) r = C_CL;
    if (in_r(c,'h00A0,'h00A0)) r = C_GL;
    if (in_r(c,'h00A2,'h00A2)) r = C_PO;
    if (in_r(c,'h00A3,'h00A3)) r = C_PR;
    if (in_r(c,'h00A5,'h00A5)) r = C_PR;
    if (in_r(c,'h00AB,'h00AB)) r = C_QU;
    if (in_r(c,'h00AD,'h00AD)) r = C_BA;
    if (in_r(c,'h00B7,'h00B7)) r = C_NS;
    if (in_r(c,'h00BB,'h00BB)) r = C_QU;
    if (in_r(c,'h1100,'h11FF)) r = C_ID;
    if (in_r(c,'h200B,'h200B)) r = C_BA;
    if (in_r(c,'h200D,'h200D)) r = C_CM;
    if (in_r(c,'h2010,'h2010)) r = C_BA;
    if (in_r(c,'h2012,'h2013)) r = C_BA;
    if (in_r(c,'h2014,'h2014)) r = C_IN;
    if (in_r(c,'h2018,'h2019)) r = C_QU;
    if (in_r(c,'h201C,'h201D)) r = C_QU;
    if (in_r(c,'h2025,'h2026)) r = C_IN;
    if (in_r(c,'h2039,'h203A)) r = C_QU;
    if (in_r(c,'h2060,'h2060)) r = C_GL;
    if (in_r(c,'h2103,'h2103)) r = C_PO;
    if (in_r(c,'h2109,'h2109)) r = C_PO;
    if (in_r(c,'h20A0,'h20CF)) r = C_PR;
    if (in_r(c,'h20E3,'h20E3)) r = C_CM;
    if (in_r(c,'h2600,'h27BF)) r = C_ID;
    if (in_r(c,'h2E3A,'h2E3A)) r = C_IN;
    if (in_r(c,'h2E80,'h2EFF)) r = C_ID;
    if (in_r(c,'h2F00,'h2FDF)) r = C_ID;
    if (in_r(c,'h3000,'h3000)) r = C_SP;
    if (in_r(c,'h3001,'h3002)) r = C_CL;
    if (in_r(c,'h3005,'h3005)) r = C_NS;
    if (in_r(c,'h3008,'h3011)) r = c[0] ? C_CL : C_OP;
    if (in_r(c,'h3014,'h301B)) r = c[0] ? C_CL : C_OP;
    if (in_r(c,'h301C,'h301C)) r = C_NS;
    if (in_r(c,'h3041,'h3049)) r = c[0] ? C_NS : C_ID;
    if (in_r(c,'h304A,'h3062)) r = C_ID;
    if (in_r(c,'h3063,'h3063)) r = C_NS;
    if (in_r(c,'h3064,'h3082)) r = C_ID;
    if (in_r(c,'h3083,'h3087)) r = c[0] ? C_NS : C_ID;
    if (in_r(c,'h3088,'h308D)) r = C_ID;
    if (in_r(c,'h308E,'h308E)) r = C_NS;
    if (in_r(c,'h308F,'h3096)) r = C_ID;
    if (in_r(c,'h309D,'h309E)) r = C_NS;
    if (in_r(c,'h309F,'h30A0)) r = C_ID;
    if (in_r(c,'h30A1,'h30A9)) r = c[0] ? C_NS : C_ID;
    if (in_r(c,'h30AA,'h30C2)) r = C_ID;
    if (in_r(c,'h30C3,'h30C3)) r = C_NS;
    if (in_r(c,'h30C4,'h30E2)) r = C_ID;
    if (in_r(c,'h30E3,'h30E7)) r = c[0] ? C_NS : C_ID;
    if (in_r(c,'h30E8,'h30ED)) r = C_ID;
    if (in_r(c,'h30EE,'h30EE)) r = C_NS;
    if (in_r(c,'h30EF,'h30F4)) r = C_ID;
    if (in_r(c,'h30F5,'h30F6)) r = C_NS;
    if (in_r(c,'h30F7,'h30FA)) r = C_ID;
    if (in_r(c,'h30FB,'h30FE)) r = C_NS;
    if (in_r(c,'h30FF,'h318F)) r = C_ID;
    if (in_r(c,'h31A0,'h31BF)) r = C_ID;
    if (in_r(c,'h31F0,'h4DBF)) r = C_ID;
    if (in_r(c,'h4E00,'h9FFF)) r = C_ID;
    if (in_r(c,'hA000,'hA4CF)) r = C_ID;
    if (in_r(c,'hAC00,'hD7AF)) r = C_ID;
    if (in_r(c,'hF900,'hFAFF)) r = C_ID;
    if (in_r(c,'hFE0E,'hFE0F)) r = C_CM;
    if (in_r(c,'hFEFF,'hFEFF)) r = C_GL;
    if (in_r(c,'hFF01,'hFF01)) r = C_EX;
    if (in_r(c,'hFF04,'hFF04)) r = C_PR;
    if (in_r(c,'hFF05,'hFF05)) r = C_PO;
    if (in_r(c,'hFF08,'hFF08)) r = C_OP;
    if (in_r(c,'hFF09,'hFF09)) r = C_CL;
    if (in_r(c,'hFF0C,'hFF0C)) r = C_CL;
    if (in_r(c,'hFF0D,'hFF0D)) r = C_BA;
    if (in_r(c,'hFF0E,'hFF0E)) r = C_CL;
    if (in_r(c,'hFF10,'hFF19)) r = C_NU;
    if (in_r(c,'hFF1A,'hFF1B)) r = C_NS;
    if (in_r(c,'hFF1F,'hFF1F)) r = C_EX;
    if (in_r(c,'hFF3B,'hFF3B)) r = C_OP;
    if (in_r(c,'hFF3D,'hFF3D)) r = C_CL;
    if (in_r(c,'hFF5B,'hFF5B)) r = C_OP;
    if (in_r(c,'hFF5D,'hFF5D)) r = C_CL;
    if (in_r(c,'hFF5F,'hFF5F)) r = C_OP;
    if (in_r(c,'hFF60,'hFF60)) r = C_CL;
    if (in_r(c,'hFF65,'hFF65)) r = C_NS;
    if (in_r(c,'hFF66,'hFF9F)) r = C_ID;
    if (in_r(c,'hFFE0,'hFFE0)) r = C_PO;
    if (in_r(c,'hFFE1,'hFFE1)) r = C_PR;
    if (in_r(c,'hFFE5,'hFFE5)) r = C_PR;
    if (in_r(c,'h1F000,'h1F0FF)) r = C_ID;
    if (in_r(c,'h1F1E0,'h1F1FF)) r = C_CM;
    if (in_r(c,'h1F300,'h1F3FA)) r = C_ID;
    if (in_r(c,'h1F3FB,'h1F3FF)) r = C_CM;
    if (in_r(c,'h1F400,'h1F64F)) r = C_ID;
    if (in_r(c,'h1F680,'h1F6FF)) r = C_ID;
    if (in_r(c,'h1F900,'h1FAFF)) r = C_ID;
    if (in_r(c,'h20000,'h2A6DF)) r = C_ID;
    if (in_r(c,'h2A700,'h2FA1F)) r = C_ID;
    if (in_r(c,'h30000,'h323AF)) r = C_ID;
    if (in_r(c,'hE0020,'hE007F)) r = C_CM;
    return r;
  endfunction

  // two bits per column, column k of the next class at bits 2k+1:2k
  localparam logic [31:0] ActRow [16] = '{
    32'haaaaaaaa, 32'h60001698, 32'h6555565a, 32'h60001658,
    32'h60001698, 32'h65555659, 32'h60001658, 32'h60001658,
    32'h60011658, 32'h65541659, 32'h61501659, 32'h61551659,
    32'h61551659, 32'h60111658, 32'h60001658, 32'h60001658
  };
endpackage

>>> rtl/lboc_classify.sv
module lboc_classify (
  input  logic [lboc_pkg::CodeW-1:0] code,
  output lboc_pkg::cls_t cls
);
  assign cls = lboc_pkg::classify(code);
endmodule

>>> rtl/lboc_decide.sv
module lboc_decide (
  input  logic [lboc_pkg::CodeW-1:0] prev_code,
  input  logic [lboc_pkg::CodeW-1:0] next_code,
  input  lboc_pkg::cls_t prev_cls,
  input  lboc_pkg::cls_t next_cls,
  output logic brk
);
  lboc_pkg::cls_t ca;
  lboc_pkg::act_t act;
  logic [31:0] row;
  logic ok;

  always_comb begin
    ok = (prev_code != lboc_pkg::CodeNul) && (next_code != lboc_pkg::CodeNul) &&
         (prev_code != lboc_pkg::CodeLf) && (next_code != lboc_pkg::CodeLf);
    ca = (prev_cls == lboc_pkg::C_CM) ? lboc_pkg::C_AL : prev_cls;
    row = lboc_pkg::ActRow[ca];
    act = row[{next_cls, 1'b0} +: 2];
    brk = 1'b0;
    if (ok && next_cls != lboc_pkg::C_CM) begin
      case (act)
        lboc_pkg::ACT_D: brk = 1'b1;
        lboc_pkg::ACT_I: brk = (ca == lboc_pkg::C_SP);
        lboc_pkg::ACT_P: brk = 1'b0;
        default: brk = 1'b0;
      endcase
    end
  end
endmodule

>>> rtl/line_break_opportunity_check.sv
// Line break check for a pair of code points. One item per cycle: an item taken
// at a start edge reaches its strobe through the input register, then the result
// register around the class decode and pair lookup. busy is always low and
// the receiver cannot stall; it must take each result in its strobe cycle.
`include "assert_macros.svh"
module line_break_opportunity_check (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [lboc_pkg::CodeW-1:0] prev_code,
  input  logic [lboc_pkg::CodeW-1:0] next_code,
  output logic done,
  output logic can_break
);
  logic [lboc_pkg::CodeW-1:0] pa, na;
  logic v1;
  lboc_pkg::cls_t pc, nc;
  logic brk_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start;
      done <= v1;
    end
    if (start) begin
      pa <= prev_code;
      na <= next_code;
    end
    can_break <= brk_next;
  end

  lboc_classify u_cp (.code(pa), .cls(pc));
  lboc_classify u_cn (.code(na), .cls(nc));
  lboc_decide u_dec (.prev_code(pa), .next_code(na), .prev_cls(pc), .next_cls(nc),
    .brk(brk_next));

  `ASSERT_NEXT(a_lat, clk, rst, start, v1)
  `ASSERT_NEXT(a_done, clk, rst, v1, done)
  `ASSERT_IMPL(a_cm, clk, rst, v1 && nc == lboc_pkg::C_CM, !brk_next)
endmodule
